>>> hw/rtl/cbe_pkg.sv
// Shared constants, types and helpers for the cubic Bezier easing block.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package cbe_pkg;

  localparam int CBE_ITERATIONS = 24;
  localparam int CBE_FRAC_BITS  = 24;

  localparam int PROGRESS_W  = 17;
  localparam int CTRL_X_W    = 17;
  localparam int CTRL_Y_W    = 19;
  localparam int EASED_W     = 19;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 19;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef logic signed [CTRL_Y_W-1:0] ctrl_t;
  typedef logic signed [EASED_W-1:0]  eased_t;

  localparam logic [CFG_INDEX_W-1:0] REG_X_CTRL_FIRST  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_CTRL_FIRST  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_X_CTRL_SECOND = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_Y_CTRL_SECOND = 8'd3;

  localparam logic [CTRL_X_W-1:0] X_CTRL_FIRST_RESET  = 17'd32768;
  localparam ctrl_t               Y_CTRL_FIRST_RESET  = 19'sd3277;
  localparam logic [CTRL_X_W-1:0] X_CTRL_SECOND_RESET = 17'd13107;
  localparam ctrl_t               Y_CTRL_SECOND_RESET = 19'sd65536;

  localparam eased_t EASED_ONE  = 19'sd65536;
  localparam eased_t EASED_ZERO = 19'sd0;
  localparam eased_t EASED_MAX  = 19'sh3FFFF;
  localparam eased_t EASED_MIN  = 19'sh40000;
  localparam int     EASED_MAX_I = 262143;
  localparam int     EASED_MIN_I = -262144;

  // Width of an exact curve coordinate in Q.(F+16), with sign and headroom.
  function automatic int cbe_sum_w(input int frac_bits);
    return frac_bits + 24;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cbe_curve.sv
// Four-stage evaluation of one cubic Bezier coordinate at parameter t.
// Uses cbe_pkg. Sideband bits ride along with each item unchanged.
`default_nettype none

module cbe_curve import cbe_pkg::*; #(
  parameter int FRAC_BITS = CBE_FRAC_BITS,
  parameter int SIDE_W    = 1
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     en,
  input  wire logic                                     in_valid,
  input  wire logic [FRAC_BITS:0]                       in_t,
  input  wire logic [SIDE_W-1:0]                        in_side,
  input  wire ctrl_t                                    ctrl_a,
  input  wire ctrl_t                                    ctrl_b,
  output logic                                          out_valid,
  output logic signed [cbe_sum_w(FRAC_BITS)-1:0]        out_sum,
  output logic [FRAC_BITS:0]                            out_t,
  output logic [SIDE_W-1:0]                             out_side
);

  localparam int TW    = FRAC_BITS + 1;
  localparam int PW    = TW + 1 + CTRL_Y_W;
  localparam int SUM_W = cbe_sum_w(FRAC_BITS);
  localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Stage 1: squares of t and 1-t.
  logic [TW-1:0]     u_c;
  logic [2*TW-1:0]   uu_full, tt_full;
  logic              s1_valid;
  logic [TW-1:0]     s1_u, s1_t, s1_uu, s1_tt;
  logic [SIDE_W-1:0] s1_side;

  assign u_c     = ONE - in_t;
  assign uu_full = u_c * u_c;
  assign tt_full = in_t * in_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_u    <= u_c;
      s1_t    <= in_t;
      s1_uu   <= uu_full[FRAC_BITS +: TW];
      s1_tt   <= tt_full[FRAC_BITS +: TW];
      s1_side <= in_side;
    end
  end

  // Stage 2: the three cubic weights, each floored back to Q.F.
  logic [2*TW-1:0]   w1_full, w2_full, w3_full;
  logic              s2_valid;
  logic [TW-1:0]     s2_t, s2_w1, s2_w2, s2_w3;
  logic [SIDE_W-1:0] s2_side;

  assign w1_full = s1_uu * s1_t;
  assign w2_full = s1_u * s1_tt;
  assign w3_full = s1_tt * s1_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_t    <= s1_t;
      s2_w1   <= w1_full[FRAC_BITS +: TW];
      s2_w2   <= w2_full[FRAC_BITS +: TW];
      s2_w3   <= w3_full[FRAC_BITS +: TW];
      s2_side <= s1_side;
    end
  end

  // Stage 3: weights times the control coordinates.
  logic signed [PW-1:0] p1_c, p2_c;
  logic                 s3_valid;
  logic [TW-1:0]        s3_t, s3_w3;
  logic signed [PW-1:0] s3_p1, s3_p2;
  logic [SIDE_W-1:0]    s3_side;

  assign p1_c = $signed({1'b0, s2_w1}) * ctrl_a;
  assign p2_c = $signed({1'b0, s2_w2}) * ctrl_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t    <= s2_t;
      s3_w3   <= s2_w3;
      s3_p1   <= p1_c;
      s3_p2   <= p2_c;
      s3_side <= s2_side;
    end
  end

  // Stage 4: 3*(p1 + p2) + w3 * 2^16, exact in Q.(F+16).
  logic signed [SUM_W-1:0] p12, sum_c, w3_term;

  assign p12     = SUM_W'(s3_p1) + SUM_W'(s3_p2);
  assign w3_term = $signed({{(SUM_W-TW-16){1'b0}}, s3_w3, 16'b0});
  assign sum_c   = (p12 <<< 1) + p12 + w3_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_t    <= s3_t;
      out_sum  <= sum_c;
      out_side <= s3_side;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cbe_step.sv
// One bisection step: curve evaluation of x(t), then bound update and midpoint.
// Uses cbe_pkg and cbe_curve. Five register stages in total.
`default_nettype none

module cbe_step import cbe_pkg::*; #(
  parameter int FRAC_BITS = CBE_FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [FRAC_BITS:0]    in_t,
  input  wire logic [FRAC_BITS:0]    in_low,
  input  wire logic [FRAC_BITS:0]    in_high,
  input  wire logic [PROGRESS_W-1:0] in_p,
  input  wire ctrl_t                 ctrl_a,
  input  wire ctrl_t                 ctrl_b,
  output logic                       out_valid,
  output logic [FRAC_BITS:0]         out_t,
  output logic [FRAC_BITS:0]         out_low,
  output logic [FRAC_BITS:0]         out_high,
  output logic [PROGRESS_W-1:0]      out_p
);

  localparam int TW     = FRAC_BITS + 1;
  localparam int SIDE_W = PROGRESS_W + 2 * TW;
  localparam int SUM_W  = cbe_sum_w(FRAC_BITS);

  logic                    c_valid;
  logic signed [SUM_W-1:0] c_sum;
  logic [TW-1:0]           c_t, c_low, c_high;
  logic [PROGRESS_W-1:0]   c_p;
  logic [SIDE_W-1:0]       c_side;

  cbe_curve #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (SIDE_W)
  ) u_curve (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_t      (in_t),
    .in_side   ({in_p, in_low, in_high}),
    .ctrl_a    (ctrl_a),
    .ctrl_b    (ctrl_b),
    .out_valid (c_valid),
    .out_sum   (c_sum),
    .out_t     (c_t),
    .out_side  (c_side)
  );

  assign {c_p, c_low, c_high} = c_side;

  // Strictly below the target moves the low bound up to t.
  logic signed [SUM_W-1:0] target;
  logic                    below;
  logic [TW-1:0]           low_next, high_next;
  logic [TW:0]             mid_sum;

  assign target    = $signed(SUM_W'({c_p, {FRAC_BITS{1'b0}}}));
  assign below     = c_sum < target;
  assign low_next  = below ? c_t : c_low;
  assign high_next = below ? c_high : c_t;
  assign mid_sum   = {1'b0, low_next} + {1'b0, high_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_t    <= mid_sum[TW:1];
      out_low  <= low_next;
      out_high <= high_next;
      out_p    <= c_p;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cbe_finish.sv
// Final y(t) evaluation, rounding to Q.16, saturation and the end-point cases.
// Uses cbe_pkg and cbe_curve. Five register stages in total.
`default_nettype none

module cbe_finish import cbe_pkg::*; #(
  parameter int FRAC_BITS = CBE_FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [FRAC_BITS:0]    in_t,
  input  wire logic [PROGRESS_W-1:0] in_p,
  input  wire ctrl_t                 ctrl_a,
  input  wire ctrl_t                 ctrl_b,
  output logic                       out_valid,
  output eased_t                     out_eased
);

  localparam int TW    = FRAC_BITS + 1;
  localparam int SUM_W = cbe_sum_w(FRAC_BITS);
  localparam int QW    = SUM_W - FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HALF =
    {{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic                    c_valid;
  logic signed [SUM_W-1:0] c_sum;
  logic [TW-1:0]           c_t;
  logic [PROGRESS_W-1:0]   c_p;

  cbe_curve #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (PROGRESS_W)
  ) u_curve (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_t      (in_t),
    .in_side   (in_p),
    .ctrl_a    (ctrl_a),
    .ctrl_b    (ctrl_b),
    .out_valid (c_valid),
    .out_sum   (c_sum),
    .out_t     (c_t),
    .out_side  (c_p)
  );

  // Adding one half and dropping the fraction rounds ties toward plus infinity.
  logic signed [SUM_W-1:0] rounded;
  logic signed [QW-1:0]    q;
  eased_t                  sat;
  eased_t                  eased_next;

  assign rounded = c_sum + HALF;
  assign q       = rounded[SUM_W-1:FRAC_BITS];

  always_comb begin
    if (q > EASED_MAX_I) begin
      sat = EASED_MAX;
    end else if (q < EASED_MIN_I) begin
      sat = EASED_MIN;
    end else begin
      sat = q[EASED_W-1:0];
    end
    // Zero progress and progress of one or more bypass the curve entirely.
    if (c_p == '0) begin
      eased_next = EASED_ZERO;
    end else if (c_p[PROGRESS_W-1]) begin
      eased_next = EASED_ONE;
    end else begin
      eased_next = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_eased <= eased_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cbe_out_skid.sv
// Output register with one skid entry, decoupling the pipeline from the receiver.
// Uses cbe_pkg for the result type only.
`default_nettype none

module cbe_out_skid import cbe_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  input  wire eased_t in_data,
  output logic        advance,
  output logic        out_valid,
  input  wire logic   out_ready,
  output eased_t      out_data
);

  logic   skid_valid;
  eased_t skid_data;
  logic   out_free;

  // The pipeline moves only while the skid entry is empty, so an item leaving
  // the last stage always has a place to land.
  assign advance  = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_free) begin
        out_data  <= in_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cubic_bezier_easing.sv
// Cubic Bezier easing curve: progress in, eased value out, one item per cycle.
// Uses cbe_pkg, cbe_step, cbe_finish and cbe_out_skid.
//
// Input stream s_axis: tdata[16:0] is progress in unsigned Q.16 (65536 is 1.0).
// Output stream m_axis: tdata[18:0] is the eased value in signed Q.16.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write the control points
// (index 0 X1, 1 Y1, 2 X2, 3 Y2); cfg_ready is always high, other indexes are
// dropped. Write only while no item is in flight.
// Throughput: one item per clock. Each bisection step is a five-stage unit
// (two product stages for the cubic weights, one for the control products, one
// for the sum, one for compare and midpoint); the final y(t) adds five more.
// Path: an accepted item passes the bisection steps, then the final y(t) stages
// and the output register before it shows on m_axis_tvalid.
// Reset (rst, synchronous) clears all valid bits and reloads the default
// control points; s_axis_tready is high right after reset.
// Stall: a result waiting on m_axis still lets one more item leave the
// pipeline into a skid entry; after that s_axis_tready drops and the whole
// pipeline holds until the receiver takes an item.
`default_nettype none

module cubic_bezier_easing import cbe_pkg::*; #(
  parameter int ITERATIONS      = CBE_ITERATIONS,
  parameter int PARAM_FRAC_BITS = CBE_FRAC_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [16:0] progress
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [18:0] eased
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int TW = PARAM_FRAC_BITS + 1;
  localparam logic [TW-1:0] ONE = {1'b1, {PARAM_FRAC_BITS{1'b0}}};

  // Control point registers.
  logic [CTRL_X_W-1:0] x_ctrl_first, x_ctrl_second;
  ctrl_t               y_ctrl_first, y_ctrl_second;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_ctrl_first  <= X_CTRL_FIRST_RESET;
      y_ctrl_first  <= Y_CTRL_FIRST_RESET;
      x_ctrl_second <= X_CTRL_SECOND_RESET;
      y_ctrl_second <= Y_CTRL_SECOND_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_CTRL_FIRST:  x_ctrl_first  <= cfg_data[CTRL_X_W-1:0];
        REG_Y_CTRL_FIRST:  y_ctrl_first  <= cfg_data;
        REG_X_CTRL_SECOND: x_ctrl_second <= cfg_data[CTRL_X_W-1:0];
        REG_Y_CTRL_SECOND: y_ctrl_second <= cfg_data;
        default: ;
      endcase
    end
  end

  ctrl_t x_a, x_b;
  assign x_a = $signed({{(CTRL_Y_W-CTRL_X_W){1'b0}}, x_ctrl_first});
  assign x_b = $signed({{(CTRL_Y_W-CTRL_X_W){1'b0}}, x_ctrl_second});

  logic advance;
  assign s_axis_tready = advance;

  // Bisection chain; entry k holds the item entering step k.
  logic                  chain_valid [ITERATIONS+1];
  logic [TW-1:0]         chain_t     [ITERATIONS+1];
  logic [TW-1:0]         chain_low   [ITERATIONS+1];
  logic [TW-1:0]         chain_high  [ITERATIONS+1];
  logic [PROGRESS_W-1:0] chain_p     [ITERATIONS+1];

  assign chain_p[0]     = s_axis_tdata[PROGRESS_W-1:0];
  assign chain_valid[0] = s_axis_tvalid;
  assign chain_t[0]     = {s_axis_tdata[PROGRESS_W-1:0], {(PARAM_FRAC_BITS-16){1'b0}}};
  assign chain_low[0]   = '0;
  assign chain_high[0]  = ONE;

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_step
    cbe_step #(
      .FRAC_BITS (PARAM_FRAC_BITS)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (chain_valid[k]),
      .in_t      (chain_t[k]),
      .in_low    (chain_low[k]),
      .in_high   (chain_high[k]),
      .in_p      (chain_p[k]),
      .ctrl_a    (x_a),
      .ctrl_b    (x_b),
      .out_valid (chain_valid[k+1]),
      .out_t     (chain_t[k+1]),
      .out_low   (chain_low[k+1]),
      .out_high  (chain_high[k+1]),
      .out_p     (chain_p[k+1])
    );
  end

  logic   fin_valid;
  eased_t fin_eased;

  cbe_finish #(
    .FRAC_BITS (PARAM_FRAC_BITS)
  ) u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (chain_valid[ITERATIONS]),
    .in_t      (chain_t[ITERATIONS]),
    .in_p      (chain_p[ITERATIONS]),
    .ctrl_a    (y_ctrl_first),
    .ctrl_b    (y_ctrl_second),
    .out_valid (fin_valid),
    .out_eased (fin_eased)
  );

  eased_t out_eased;

  cbe_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fin_valid),
    .in_data   (fin_eased),
    .advance   (advance),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_eased)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-EASED_W){1'b0}}, out_eased};

endmodule

`default_nettype wire

>>> hw/rtl/cbe_checker.sv
// Port-level checks for cubic_bezier_easing, attached by the bind below.
// Uses cbe_pkg for the stream widths.
`default_nettype none

module cbe_checker import cbe_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // Input backpressure only appears after the receiver held off a result.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // While the input is held off, a result is on offer.
  a_stall_has_out: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output item pending");

  // The padding bits above the eased value stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:EASED_W] == '0)
    else $error("output padding bits not zero");

endmodule

bind cubic_bezier_easing cbe_checker u_cbe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for cubic_bezier_easing: streams progress items through
// the block under several control-point settings and checks each eased item.
// Depends on cbe_pkg and the cubic_bezier_easing RTL only.
`default_nettype none

module tb_top;
  import cbe_pkg::*;

  localparam int ITER        = CBE_ITERATIONS;
  localparam int FRAC        = CBE_FRAC_BITS;
  localparam int LATENCY     = 5 * ITER + 6;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 200000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'hFF;

  typedef struct packed {
    logic [PROGRESS_W-1:0] progress;
    eased_t                eased;
  } ease_check_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [16:0] progress
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [18:0] eased
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Control points as the block should hold them.
  logic [CTRL_X_W-1:0] pt1_x = X_CTRL_FIRST_RESET;
  ctrl_t               pt1_y = Y_CTRL_FIRST_RESET;
  logic [CTRL_X_W-1:0] pt2_x = X_CTRL_SECOND_RESET;
  ctrl_t               pt2_y = Y_CTRL_SECOND_RESET;

  logic [PROGRESS_W-1:0] progress_q[$];
  ease_check_t           eased_due_q[$];
  ease_check_t           offered;
  ease_check_t           due;

  int idle_pct    = 27;
  int stall_pct   = 27;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left   = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  cubic_bezier_easing DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // Product of two Q.F fractions, floored back to Q.F.
  function automatic longint unsigned frac_mul(input longint unsigned a,
                                               input longint unsigned b);
    return (a * b) >> FRAC;
  endfunction

  // One curve coordinate in Q.(F+16) at parameter t for control values a, b.
  function automatic longint curve_coord(input longint unsigned t, input longint a,
                                         input longint b);
    longint unsigned u, uu, tt, w1, w2, w3;
    u  = (longint'(1) << FRAC) - t;
    uu = frac_mul(u, u);
    w1 = frac_mul(uu, t);
    tt = frac_mul(t, t);
    w2 = frac_mul(u, tt);
    w3 = frac_mul(tt, t);
    return 3 * longint'(w1) * a + 3 * longint'(w2) * b + longint'(w3 << 16);
  endfunction

  // Bisects x(t) = progress, then evaluates y at the final parameter.
  function automatic eased_t ease_value(input logic [PROGRESS_W-1:0] progress);
    longint target, y;
    longint unsigned lo, hi, t;
    if (progress == '0)
      return EASED_ZERO;
    if (progress >= PROGRESS_W'(65536))
      return EASED_ONE;
    target = longint'(progress) << FRAC;
    lo = 0;
    hi = longint'(1) << FRAC;
    t  = longint'(progress) << (FRAC - 16);
    for (int i = 0; i < ITER; i++) begin
      if (curve_coord(t, longint'(pt1_x), longint'(pt2_x)) < target)
        lo = t;
      else
        hi = t;
      t = (lo + hi) >> 1;
    end
    y = curve_coord(t, longint'(pt1_y), longint'(pt2_y)) + (longint'(1) << (FRAC - 1));
    y = y >>> FRAC;
    if (y > EASED_MAX_I) y = EASED_MAX_I;
    if (y < EASED_MIN_I) y = EASED_MIN_I;
    return eased_t'(y);
  endfunction

  function automatic logic [PROGRESS_W-1:0] random_progress();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 4)
      return '0;
    if (sel < 12)
      return PROGRESS_W'($urandom_range(131071, 65536));
    if (sel < 16)
      return PROGRESS_W'($urandom_range(16, 1));
    if (sel < 20)
      return PROGRESS_W'(65535 - $urandom_range(16));
    return PROGRESS_W'($urandom_range(65535, 1));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Leaves cfg_valid high so back-to-back writes need no extra edge.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_X_CTRL_FIRST:  pt1_x = data[CTRL_X_W-1:0];
      REG_Y_CTRL_FIRST:  pt1_y = ctrl_t'(data);
      REG_X_CTRL_SECOND: pt2_x = data[CTRL_X_W-1:0];
      REG_Y_CTRL_SECOND: pt2_y = ctrl_t'(data);
      default: ;
    endcase
  endtask

  task automatic load_curve(input int x1, input int y1, input int x2, input int y2,
                            input bit poke_unused);
    @(posedge clk);
    write_reg(REG_X_CTRL_FIRST, CFG_DATA_W'(x1));
    write_reg(REG_Y_CTRL_FIRST, CFG_DATA_W'(y1));
    write_reg(REG_X_CTRL_SECOND, CFG_DATA_W'(x2));
    write_reg(REG_Y_CTRL_SECOND, CFG_DATA_W'(y2));
    if (poke_unused)
      write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random(input int count);
    @(negedge clk);
    repeat (count) progress_q.push_back(random_progress());
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (progress_q.size() != 0 || s_axis_tvalid || eased_due_q.size() != 0);
  endtask

  function automatic int random_y();
    return int'($urandom_range(327680)) - 131072;
  endfunction

  // Sender: offers the next pending progress item whenever the slot is free.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        offered.progress = s_axis_tdata[PROGRESS_W-1:0];
        offered.eased    = ease_value(offered.progress);
        eased_due_q.push_back(offered);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (progress_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_TDATA_W'(progress_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold, counted here, lets the pipeline fill up and stall
  // the input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: checks each eased item and applies back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (eased_due_q.size() == 0) begin
          report_mismatch($sformatf("eased %0d arrived with nothing outstanding",
                                    $signed(m_axis_tdata[EASED_W-1:0])));
        end else begin
          due = eased_due_q.pop_front();
          if (m_axis_tdata[EASED_W-1:0] !== due.eased)
            report_mismatch($sformatf("progress %0d: eased %0d, predicted %0d",
                                      due.progress, $signed(m_axis_tdata[EASED_W-1:0]),
                                      due.eased));
        end
      end
      if (hold_left > 0 || (hold_req && !hold_done)) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [PROGRESS_W-1:0] directed[$];
    directed = {17'd0, 17'd1, 17'd2, 17'd65535, 17'd65536, 17'd65537, 17'd131071,
                17'd32768, 17'd16384, 17'd49152, 17'h15555, 17'h0AAAA, 17'd100,
                17'd65000, 17'd256, 17'd98304};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Default curve after reset, directed progress values.
    @(negedge clk);
    foreach (directed[i]) progress_q.push_back(directed[i]);
    wait_idle();

    // Common ease curve, then the control points at their extremes.
    load_curve(16384, 6554, 16384, 65536, 1'b0);
    foreach (directed[i]) progress_q.push_back(directed[i]);
    queue_random(30);
    wait_idle();
    load_curve(0, -131072, 65536, 196608, 1'b0);
    queue_random(50);
    wait_idle();
    load_curve(65536, 196608, 0, -131072, 1'b1);
    queue_random(50);
    wait_idle();

    // X beyond one gives a curve that is not monotonic; Y at the 19-bit limits.
    load_curve(131071, 262143, 100000, -262144, 1'b0);
    queue_random(50);
    wait_idle();

    // A stretch with no idling on either side, and the long receiver hold.
    load_curve($urandom_range(65536), random_y(), $urandom_range(65536), random_y(), 1'b0);
    @(negedge clk);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    queue_random(200);
    wait_idle();
    idle_pct  = 27;
    stall_pct = 27;

    repeat (3) begin
      load_curve($urandom_range(65536), random_y(), $urandom_range(65536), random_y(),
                 1'b0);
      queue_random(50);
      wait_idle();
    end

    // Raw 19-bit words on every register; X writes keep their low 17 bits.
    load_curve($urandom_range(524287), $urandom_range(524287), $urandom_range(524287),
               $urandom_range(524287), 1'b0);
    queue_random(50);
    wait_idle();

    repeat (LATENCY + 20) @(posedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
